@@ src/edfts_pkg.sv @@
package edfts_pkg;

  // Default sizing of the task row
  localparam int unsigned NumTasksDef = 8;
  localparam int unsigned TimeBitsDef = 16;

  // Fixed widths of the item fields
  localparam int unsigned OpW     = 1;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned RunTskW = 4;

  // Item operation codes
  localparam logic [OpW-1:0] OpTick = 1'b0;
  localparam logic [OpW-1:0] OpLoad = 1'b1;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;       // write the addressed task entry
    logic commit;     // apply the tick result to all cells
    logic win_found;  // a task was granted on this tick
  } cell_ctrl_t;

endpackage

@@ src/edfts_cell.sv @@
module edfts_cell
  import edfts_pkg::*;
#(
  parameter int unsigned CellIdx  = 0,
  parameter int unsigned TimeBits = TimeBitsDef,
  parameter int unsigned IdxW     = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [FieldW-1:0]   period_i,
  input  logic [FieldW-1:0]   budget_i,
  input  logic [IdxW-1:0]     win_idx_i,
  input  logic                best_found_i,
  input  logic [TimeBits-1:0] best_margin_i,
  input  logic [IdxW-1:0]     best_idx_i,
  output logic                best_found_o,
  output logic [TimeBits-1:0] best_margin_o,
  output logic [IdxW-1:0]     best_idx_o
);

  logic [TimeBits-1:0] period_q, period_d;
  logic [TimeBits-1:0] budget_q, budget_d;
  logic [TimeBits-1:0] phase_q, phase_d;
  logic [TimeBits-1:0] runs_q, runs_d;
  logic                found_q;
  logic [TimeBits-1:0] margin_q;
  logic [IdxW-1:0]     idx_q;

  logic                eligible;
  logic [TimeBits-1:0] margin;
  logic                take;
  logic                slot_hit;
  logic                win;
  logic [TimeBits-1:0] runs_inc;
  logic [TimeBits-1:0] phase_inc;

  // Rank this task against the best candidate handed in from the left
  assign eligible = (period_q != '0) && (runs_q < budget_q);
  assign margin   = period_q - phase_q;
  assign take     = eligible && (!best_found_i || (margin < best_margin_i));

  assign slot_hit  = (CellIdx < (1 << SlotW)) && (32'(slot_i) == CellIdx);
  assign win       = ctrl_i.win_found && (win_idx_i == IdxW'(CellIdx));
  assign runs_inc  = (win && (runs_q != '1)) ? runs_q + 1'b1 : runs_q;
  assign phase_inc = phase_q + 1'b1;

  // Next task state: load, or on a commit step phase and run count
  always_comb begin
    period_d = period_q;
    budget_d = budget_q;
    phase_d  = phase_q;
    runs_d   = runs_q;
    if (ctrl_i.load && slot_hit) begin
      period_d = TimeBits'(period_i);
      budget_d = TimeBits'(budget_i);
      phase_d  = '0;
      runs_d   = '0;
    end else if (ctrl_i.commit) begin
      if ((period_q == '0) || (phase_inc >= period_q)) begin
        phase_d = '0;
        runs_d  = '0;
      end else begin
        phase_d = phase_inc;
        runs_d  = runs_inc;
      end
    end
  end

  // Hold the task entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      budget_q <= '0;
      phase_q  <= '0;
      runs_q   <= '0;
    end else begin
      period_q <= period_d;
      budget_q <= budget_d;
      phase_q  <= phase_d;
      runs_q   <= runs_d;
    end
  end

  // Pass the best candidate so far to the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= best_found_i || eligible;
    end
  end

  always_ff @(posedge clk_i) begin
    margin_q <= take ? margin : best_margin_i;
    idx_q    <= take ? IdxW'(CellIdx) : best_idx_i;
  end

  assign best_found_o  = found_q;
  assign best_margin_o = margin_q;
  assign best_idx_o    = idx_q;

endmodule

@@ src/edf_tick_scheduler.sv @@
// Earliest-deadline-first tick scheduler for up to NUM_TASKS periodic tasks.
// Input channel (in_valid_i / in_stall_o) takes load and tick items. A load
// item writes one task's period and budget and clears its phase and run
// count; it gives no result. A tick item gives exactly one result on the
// output channel (out_valid_o / out_stall_i): running_task_o, the 1-based
// granted task, or 0 when no task is eligible. Each task lives in one cell
// of a row; the best candidate moves one cell to the right per cycle, and
// once it has crossed the row the tick is committed; a new tick is taken
// only after the previous one has committed.
// in_stall_o is high while a tick is being ranked or committed.
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when the following tick is ready to
// commit, that commit waits until the output register is free.
// Reset disables every task and empties the output register.
module edf_tick_scheduler
  import edfts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = NumTasksDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [SlotW-1:0]    task_slot_i,
  input  logic [FieldW-1:0]   task_period_i,
  input  logic [FieldW-1:0]   task_budget_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RunTskW-1:0]  running_task_o
);

  localparam int unsigned IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CntW = IdxW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [RunTskW-1:0] running_q;

  logic               accept;
  logic               commit_go;
  cell_ctrl_t         ctrl;

  logic                found_w  [NUM_TASKS+1];
  logic [TIME_BITS-1:0] margin_w [NUM_TASKS+1];
  logic [IdxW-1:0]    idx_w    [NUM_TASKS+1];

  logic [IdxW:0]      task_num;

  assign accept    = in_valid_i && !in_stall_o;
  assign commit_go = (state_q == StCommit) && (!out_valid_q || !out_stall_i);

  // Broadcast control to the cells
  assign ctrl.load      = accept && (opcode_i == OpLoad);
  assign ctrl.commit    = commit_go;
  assign ctrl.win_found = commit_go && found_w[NUM_TASKS];

  // Empty candidate enters the left end of the row
  assign found_w[0]  = 1'b0;
  assign margin_w[0] = '0;
  assign idx_w[0]    = '0;

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    edfts_cell #(
      .CellIdx  (g),
      .TimeBits (TIME_BITS),
      .IdxW     (IdxW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .slot_i        (task_slot_i),
      .period_i      (task_period_i),
      .budget_i      (task_budget_i),
      .win_idx_i     (idx_w[NUM_TASKS]),
      .best_found_i  (found_w[g]),
      .best_margin_i (margin_w[g]),
      .best_idx_i    (idx_w[g]),
      .best_found_o  (found_w[g+1]),
      .best_margin_o (margin_w[g+1]),
      .best_idx_o    (idx_w[g+1])
    );
  end

  // Sequence a tick: let the candidate cross the row, then commit
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (opcode_i == OpTick)) begin
          state_d = StScan;
          cnt_d   = '0;
        end
      end
      StScan: begin
        if (cnt_q == CntW'(NUM_TASKS - 1)) begin
          state_d = StCommit;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCommit: begin
        if (commit_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (commit_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Turn the winner into a 1-based task number
  assign task_num = {1'b0, idx_w[NUM_TASKS]} + (IdxW + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      running_q <= found_w[NUM_TASKS] ? RunTskW'(task_num) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_task_o = running_q;

endmodule

@@ dv/tb.sv @@
module tb;
  import edfts_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned SettleCycles = 4 * (NumTasksDef + 2);
  localparam int unsigned RandomItems = 1600;

  typedef struct {
    logic               pause;
    logic [OpW-1:0]     op;
    logic [SlotW-1:0]   slot;
    logic [FieldW-1:0]  period;
    logic [FieldW-1:0]  budget;
    int unsigned        gap;
  } sched_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [OpW-1:0]     opcode = OpTick;
  logic [SlotW-1:0]   task_slot = '0;
  logic [FieldW-1:0]  task_period = '0;
  logic [FieldW-1:0]  task_budget = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [RunTskW-1:0] running_task_o;

  // Shadow of the task row
  logic [TimeBitsDef-1:0] period_tab [NumTasksDef];
  logic [TimeBitsDef-1:0] budget_tab [NumTasksDef];
  logic [TimeBitsDef-1:0] phase_cnt  [NumTasksDef];
  logic [TimeBitsDef-1:0] run_cnt    [NumTasksDef];

  sched_item_t        item_q [$];
  logic [RunTskW-1:0] grant_q [$];

  sched_item_t  cur_item, next_item;
  logic         have_next = 1'b0;
  logic         next_valid;
  int unsigned  gap_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  items_total = 0;
  int unsigned  items_taken = 0;
  int unsigned  grants_seen = 0;
  int unsigned  errors = 0;
  logic         calm = 1'b0;
  logic         timed_out = 1'b0;
  logic [RunTskW-1:0] want;

  edf_tick_scheduler dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode),
    .task_slot_i    (task_slot),
    .task_period_i  (task_period),
    .task_budget_i  (task_budget),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .running_task_o (running_task_o)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Rank eligible tasks by margin, grant the tightest, then advance all phases
  function automatic logic [RunTskW-1:0] take_tick();
    logic                   found;
    int unsigned            best;
    logic [TimeBitsDef-1:0] best_margin;
    logic [TimeBitsDef-1:0] margin;
    logic [TimeBitsDef-1:0] next_ph;
    found = 1'b0;
    best = 0;
    best_margin = '0;
    for (int i = 0; i < NumTasksDef; i++) begin
      if (period_tab[i] != '0 && run_cnt[i] < budget_tab[i]) begin
        margin = period_tab[i] - phase_cnt[i];
        if (!found || margin < best_margin) begin
          found = 1'b1;
          best = i;
          best_margin = margin;
        end
      end
    end
    if (found && run_cnt[best] != '1) run_cnt[best]++;
    for (int i = 0; i < NumTasksDef; i++) begin
      next_ph = phase_cnt[i] + 1'b1;
      if (period_tab[i] == '0 || next_ph >= period_tab[i]) begin
        phase_cnt[i] = '0;
        run_cnt[i] = '0;
      end else begin
        phase_cnt[i] = next_ph;
      end
    end
    return found ? RunTskW'(best + 1) : '0;
  endfunction

  // Update the shadow row for one accepted item
  task automatic apply_item(input sched_item_t it);
    if (it.op == OpLoad) begin
      if (it.slot < NumTasksDef) begin
        period_tab[it.slot] = it.period;
        budget_tab[it.slot] = it.budget;
        phase_cnt[it.slot] = '0;
        run_cnt[it.slot] = '0;
      end
    end else begin
      grant_q.push_back(take_tick());
    end
  endtask

  task automatic push_item(input logic [OpW-1:0] op, input int unsigned slot,
                           input int unsigned per, input int unsigned bud);
    sched_item_t it;
    it.pause = 1'b0;
    it.op = op;
    it.slot = slot[SlotW-1:0];
    it.period = per[FieldW-1:0];
    it.budget = bud[FieldW-1:0];
    it.gap = calm ? 0 : $urandom_range(0, 6);
    item_q.push_back(it);
    items_total++;
  endtask

  task automatic push_tick();
    push_item(OpTick, $urandom_range(0, 7), $urandom, $urandom);
  endtask

  task automatic push_load(input int unsigned slot, input int unsigned per,
                           input int unsigned bud);
    push_item(OpLoad, slot, per, bud);
  endtask

  task automatic push_pause();
    sched_item_t it;
    it.pause = 1'b1;
    it.op = OpTick;
    it.slot = '0;
    it.period = '0;
    it.budget = '0;
    it.gap = 0;
    item_q.push_back(it);
  endtask

  // Mostly short periods, now and then disabled or full-width
  function automatic int unsigned pick_period();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom & 16'hFFFF;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic int unsigned pick_budget(input int unsigned per);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom & 16'hFFFF;
      2:       return $urandom_range(0, 3);
      default: return (per > 24) ? $urandom_range(1, 24) : $urandom_range(0, per);
    endcase
  endfunction

  // Driver: predict on acceptance, then offer the next item after its gap
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        apply_item(cur_item);
        items_taken++;
      end
      if (!(in_valid && in_stall_o)) begin
        next_valid = 1'b0;
        if (!have_next && item_q.size() > 0) begin
          next_item = item_q.pop_front();
          gap_left = next_item.gap;
          have_next = 1'b1;
        end
        if (have_next) begin
          if (next_item.pause) begin
            // hold until every outstanding grant has come back
            if (grant_q.size() == 0) have_next = 1'b0;
          end else if (gap_left > 0) begin
            gap_left--;
          end else begin
            cur_item = next_item;
            have_next = 1'b0;
            next_valid = 1'b1;
            opcode <= next_item.op;
            task_slot <= next_item.slot;
            task_period <= next_item.period;
            task_budget <= next_item.budget;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor: check each grant in order and draw the stall before the next
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected grant, expected none, actual %0d",
                   $time, running_task_o);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (running_task_o !== want) begin
            $display("%0t: running_task mismatch, expected %0d, actual %0d",
                     $time, want, running_task_o);
            errors++;
          end
        end
        grants_seen++;
        if (grants_seen == 300) hold_left = 150;
        else if ((grants_seen / 100) % 5 == 4) hold_left = 0;
        else hold_left = $urandom_range(0, 6);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n && !timed_out) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
          timed_out = 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    for (int i = 0; i < NumTasksDef; i++) begin
      period_tab[i] = '0;
      budget_tab[i] = '0;
      phase_cnt[i] = '0;
      run_cnt[i] = '0;
    end

    // Directed: idle row, extremes, disable, zero budget, ties, wrap
    push_tick();
    push_load(0, 16'hFFFF, 16'hFFFF);
    push_load(7, 1, 1);
    push_tick();
    push_tick();
    push_load(3, 0, 5);
    push_load(4, 10, 0);
    push_load(1, 4, 2);
    push_load(2, 4, 2);
    push_load(7, 0, 0);
    repeat (6) push_tick();
    push_load(5, 3, 16'hFFFF);
    repeat (4) push_tick();
    push_load(0, 0, 0);
    push_pause();
    repeat (2) push_tick();

    // Random: load a task set, then run it, with loads dropped in mid-run
    while (items_total < RandomItems + 25) begin
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, NumTasksDef);
      repeat (n) begin
        automatic int unsigned per = pick_period();
        push_load($urandom_range(0, 7), per, pick_budget(per));
      end
      repeat ($urandom_range(20, 80)) begin
        if ($urandom_range(0, 19) == 0) begin
          automatic int unsigned per = pick_period();
          push_load($urandom_range(0, 7), per, pick_budget(per));
        end else begin
          push_tick();
        end
      end
      if ($urandom_range(0, 5) == 0) push_pause();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait ((items_taken == items_total && grant_q.size() == 0) || timed_out);
    if (!timed_out) repeat (SettleCycles) @(posedge clk);

    if (errors == 0 && !timed_out && grant_q.size() == 0) begin
      $display("[edf_tick_scheduler] OK");
    end else begin
      $display("[edf_tick_scheduler] ERROR");
    end
    $finish;
  end

endmodule
